/* rtl/wsfp_pkg.sv */
// types and constants for the websocket frame parser
// no dependencies
`default_nettype none

package wsfp_pkg;

  typedef enum logic [2:0] {
    PH_FIRST   = 3'd0,
    PH_SECOND  = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_MASK    = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    ST_BYTE   = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_REJECT = 2'd2
  } status_e;

  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [3:0] OP_PONG   = 4'hA;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] MASK_BYTES  = 4'd4;

  function automatic logic opcode_ok(input logic [3:0] op);
    return (op == OP_TEXT) || (op == OP_BINARY) || (op == OP_CLOSE) ||
           (op == OP_PING) || (op == OP_PONG);
  endfunction

endpackage

`default_nettype wire

/* rtl/websocket_frame_parser.sv */
// websocket frame parser top level: header decode, length, mask key, payload unmasking
// depends on wsfp_pkg
//
// usage
//   slave stream carries the received byte stream, one byte per request
//   master stream gives one result per payload byte, one per empty frame and one per
//   rejected first header byte; header, length and mask key bytes give no result
//   tuser holds the status, tlast marks the last payload byte or an empty frame
// timing
//   a byte accepted is held in the input register, is parsed into the output register
//   once the output can take a result and is offered from there on tvalid
//   one byte per cycle while output is taken, set by the single parse step per cycle
// reset
//   rst_ni clears both stage valids and puts the parser at the first header byte
// stalls
//   while the output request is held the parse step waits; the input register still
//   takes one more byte, then tready falls until the output is taken
`default_nettype none

module websocket_frame_parser #(
  parameter int LENGTH_BITS = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [15:0]      m_axis_tdata_o,   // [7:0] payload_byte, [11:8] opcode,
                                             // [12] was_masked, [15:13] zero
  output logic [1:0]       m_axis_tuser_o,   // [1:0] status
  output logic             m_axis_tlast_o    // frame_end
);
  import wsfp_pkg::*;

  logic                   in_v_q;
  logic [7:0]             in_byte_q;
  logic                   proc_ok;
  logic                   proc;
  logic                   reject;

  phase_e                 phase_q, phase_d;
  logic [3:0]             op_q, op_d;
  logic                   mask_q, mask_d;
  logic [3:0]             left_q, left_d;
  logic [LENGTH_BITS-1:0] rem_q, rem_d;
  logic [3:0][7:0]        key_q, key_d;
  logic [1:0]             pos_q, pos_d;
  logic                   hdr_empty;

  logic                   res_v;
  status_e                res_status;
  logic [7:0]             res_byte;
  logic [3:0]             res_op;
  logic                   res_masked;
  logic                   res_end;

  logic                   out_v_q;
  status_e                out_status_q;
  logic [7:0]             out_byte_q;
  logic [3:0]             out_op_q;
  logic                   out_masked_q;
  logic                   out_end_q;

  assign proc_ok         = !out_v_q || m_axis_tready_i;
  assign proc            = in_v_q && proc_ok;
  assign s_axis_tready_o = !in_v_q || proc_ok;
  assign reject          = !in_byte_q[7] || !opcode_ok(in_byte_q[3:0]);

  // next state
  always_comb begin
    logic       done;
    logic [6:0] len7;
    phase_d   = phase_q;
    op_d      = op_q;
    mask_d    = mask_q;
    left_d    = left_q;
    rem_d     = rem_q;
    key_d     = key_q;
    pos_d     = pos_q;
    done      = 1'b0;
    hdr_empty = 1'b0;
    len7      = in_byte_q[6:0];
    if (proc) begin
      case (phase_q)
        PH_SECOND: begin
          mask_d = in_byte_q[7];
          key_d  = '0;
          if ((len7 == LEN_EXT16) || (len7 == LEN_EXT64)) begin
            rem_d   = '0;
            left_d  = (len7 == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
            phase_d = PH_EXTLEN;
          end else begin
            rem_d = LENGTH_BITS'(len7);
            if (in_byte_q[7]) begin
              left_d  = MASK_BYTES;
              phase_d = PH_MASK;
            end else begin
              done = 1'b1;
            end
          end
        end
        PH_EXTLEN: begin
          rem_d  = {rem_q[LENGTH_BITS-9:0], in_byte_q};
          left_d = left_q - 4'd1;
          if (left_d == 4'd0) begin
            if (mask_q) begin
              left_d  = MASK_BYTES;
              phase_d = PH_MASK;
            end else begin
              done = 1'b1;
            end
          end
        end
        PH_MASK: begin
          key_d  = {key_q[2:0], in_byte_q};
          left_d = left_q - 4'd1;
          if (left_d == 4'd0) begin
            done = 1'b1;
          end
        end
        PH_PAYLOAD: begin
          pos_d = pos_q + 2'd1;
          rem_d = rem_q - LENGTH_BITS'(1);
          if (rem_q == LENGTH_BITS'(1)) begin
            phase_d = PH_FIRST;
          end
        end
        default: begin
          if (reject) begin
            phase_d = PH_FIRST;
          end else begin
            op_d    = in_byte_q[3:0];
            phase_d = PH_SECOND;
          end
        end
      endcase
      if (done) begin
        pos_d = 2'd0;
        if (rem_d == '0) begin
          hdr_empty = 1'b1;
          phase_d   = PH_FIRST;
        end else begin
          phase_d = PH_PAYLOAD;
        end
      end
    end
  end

  // result of the parse step
  always_comb begin
    res_v      = 1'b0;
    res_status = ST_BYTE;
    res_byte   = 8'd0;
    res_op     = op_q;
    res_masked = mask_d;
    res_end    = 1'b0;
    case (phase_q)
      PH_SECOND, PH_EXTLEN, PH_MASK: begin
        res_v      = proc && hdr_empty;
        res_status = ST_EMPTY;
        res_end    = 1'b1;
      end
      PH_PAYLOAD: begin
        res_v    = proc;
        res_byte = in_byte_q ^ (mask_q ? key_q[~pos_q] : 8'd0);
        res_end  = (rem_q == LENGTH_BITS'(1));
      end
      default: begin
        res_v      = proc && reject;
        res_status = ST_REJECT;
        res_op     = in_byte_q[3:0];
        res_masked = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      phase_q <= PH_FIRST;
    end else begin
      if (s_axis_tready_o) begin
        in_v_q <= s_axis_tvalid_i;
      end
      if (proc_ok) begin
        out_v_q <= res_v;
      end
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_byte_q <= s_axis_tdata_i;
    end
    op_q   <= op_d;
    mask_q <= mask_d;
    left_q <= left_d;
    rem_q  <= rem_d;
    key_q  <= key_d;
    pos_q  <= pos_d;
    if (res_v) begin
      out_status_q <= res_status;
      out_byte_q   <= res_byte;
      out_op_q     <= res_op;
      out_masked_q <= res_masked;
      out_end_q    <= res_end;
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = {3'b000, out_masked_q, out_op_q, out_byte_q};
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tlast_o  = out_end_q;

  a_payload_left : assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAYLOAD |-> rem_q != '0)
    else $error("payload phase with no bytes left");

  a_header_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_EXTLEN || phase_q == PH_MASK) |-> left_q != 4'd0)
    else $error("header byte count empty inside header");

  a_input_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_v_q && !proc_ok |=> in_v_q && $stable(in_byte_q))
    else $error("input register lost a byte during a stall");

  a_reject_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_status_q == ST_REJECT |-> !out_end_q && out_byte_q == 8'd0
      && !out_masked_q)
    else $error("rejected header result carries frame data");

endmodule

`default_nettype wire

/* tb/websocket_frame_parser_tb.sv */
// testbench for websocket_frame_parser: directed and random byte streams with a frame predictor
// and an in-order result check; random idling on both stream sides
// depends on wsfp_pkg and websocket_frame_parser
`default_nettype none

module websocket_frame_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wsfp_pkg::*;

  localparam int LEN_BITS = 64;
  localparam int RANDOM_BYTES = 650;
  localparam logic [3:0] OP_CONT = 4'h0;
  localparam logic [3:0] OP_RSVD = 4'hF;

  typedef enum int {FORM_SHORT, FORM_EXT16, FORM_EXT64} len_form_e;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] data;
    logic [3:0] op;
    logic       masked;
    logic       last;
  } frame_result_t;

  class frame_scoreboard;
    phase_e          phase;
    logic [3:0]      frame_op;
    logic            masked;
    logic [3:0]      hdr_left;
    logic [63:0]     remaining;
    logic [31:0]     key;
    logic [1:0]      key_pos;
    frame_result_t   expected_q[$];
    int              errors;

    function new();
      phase = PH_FIRST;
      frame_op = '0;
      masked = 1'b0;
      hdr_left = '0;
      remaining = '0;
      key = '0;
      key_pos = '0;
      errors = 0;
    endfunction

    static function bit known_opcode(logic [3:0] op);
      return op == OP_TEXT || op == OP_BINARY || op == OP_CLOSE || op == OP_PING ||
             op == OP_PONG;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function logic [63:0] len_mask();
      return {64{1'b1}} >> (64 - LEN_BITS);
    endfunction

    function void header_finished();
      key_pos = '0;
      if (remaining == 0) begin
        phase = PH_FIRST;
        expected_q.push_back('{ST_EMPTY, 8'h00, frame_op, masked, 1'b1});
      end else begin
        phase = PH_PAYLOAD;
      end
    endfunction

    function void note_request(logic [7:0] b);
      logic [7:0] v;
      case (phase)
        PH_SECOND: begin
          masked = b[7];
          key = '0;
          if (b[6:0] == LEN_EXT16 || b[6:0] == LEN_EXT64) begin
            remaining = '0;
            hdr_left = (b[6:0] == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
            phase = PH_EXTLEN;
          end else begin
            remaining = 64'(b[6:0]) & len_mask();
            if (masked) begin
              hdr_left = MASK_BYTES;
              phase = PH_MASK;
            end else begin
              header_finished();
            end
          end
        end
        PH_EXTLEN: begin
          remaining = {remaining[55:0], b} & len_mask();
          hdr_left = hdr_left - 4'd1;
          if (hdr_left == 0) begin
            if (masked) begin
              hdr_left = MASK_BYTES;
              phase = PH_MASK;
            end else begin
              header_finished();
            end
          end
        end
        PH_MASK: begin
          key = {key[23:0], b};
          hdr_left = hdr_left - 4'd1;
          if (hdr_left == 0) header_finished();
        end
        PH_PAYLOAD: begin
          v = masked ? (b ^ key[(3 - key_pos) * 8 +: 8]) : b;
          key_pos = key_pos + 2'd1;
          remaining = (remaining - 64'd1) & len_mask();
          if (remaining == 0) phase = PH_FIRST;
          expected_q.push_back('{ST_BYTE, v, frame_op, masked, remaining == 0});
        end
        default: begin
          phase = PH_FIRST;
          if (!b[7] || !known_opcode(b[3:0])) begin
            expected_q.push_back('{ST_REJECT, 8'h00, b[3:0], 1'b0, 1'b0});
          end else begin
            frame_op = b[3:0];
            phase = PH_SECOND;
          end
        end
      endcase
    endfunction

    function void check_result(frame_result_t got);
      frame_result_t exp;
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: status %0d byte %02h", got.status, got.data);
        errors++;
        return;
      end
      exp = expected_q.pop_front();
      if (got.status !== exp.status) begin
        $error("status expected %0d got %0d", exp.status, got.status);
        errors++;
      end
      if (got.data !== exp.data) begin
        $error("payload_byte expected %02h got %02h", exp.data, got.data);
        errors++;
      end
      if (got.op !== exp.op) begin
        $error("opcode expected %0h got %0h", exp.op, got.op);
        errors++;
      end
      if (got.masked !== exp.masked) begin
        $error("was_masked expected %0b got %0b", exp.masked, got.masked);
        errors++;
      end
      if (got.last !== exp.last) begin
        $error("frame_end expected %0b got %0b", exp.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  frame_scoreboard sb = new();

  int bytes_sent = 0;
  int burst_left = 0;
  int stall_mode = 0;
  int stall_left = 0;

  websocket_frame_parser #(
    .LENGTH_BITS(LEN_BITS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata),
    .m_axis_tuser_o (m_axis_tuser),
    .m_axis_tlast_o (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // receiver stall pattern: always ready, coin toss, or mostly stalled
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(16, 80);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      default: m_axis_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_result('{m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[11:8],
                        m_axis_tdata[12], m_axis_tlast});
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(b);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [3:0] op, input bit masked, input len_form_e form,
                            input logic [63:0] len, input int unsigned n_bytes);
    logic [31:0] key;
    key = $urandom;
    send_byte({1'b1, 3'($urandom), op});
    case (form)
      FORM_EXT16: begin
        send_byte({masked, LEN_EXT16});
        send_byte(len[15:8]);
        send_byte(len[7:0]);
      end
      FORM_EXT64: begin
        send_byte({masked, LEN_EXT64});
        for (int i = 7; i >= 0; i--) send_byte(len[8 * i +: 8]);
      end
      default: send_byte({masked, len[6:0]});
    endcase
    if (masked) begin
      for (int i = 3; i >= 0; i--) send_byte(key[8 * i +: 8]);
    end
    repeat (n_bytes) send_byte(8'($urandom));
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  initial begin
    logic [3:0]  valid_ops[5];
    logic [7:0]  noise;
    logic [63:0] len;
    len_form_e   form;
    int          start;
    int          pick;
    bit          long_done;
    bit          paused;

    valid_ops = '{OP_TEXT, OP_BINARY, OP_CLOSE, OP_PING, OP_PONG};
    long_done = 1'b0;
    paused = 1'b0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // rejected headers: final bit clear, opcode at both ends; then empty frames and a one-byte frame
    send_byte({1'b0, 3'b000, OP_TEXT});
    send_byte({1'b1, 3'b000, OP_CONT});
    send_byte({1'b1, 3'b111, OP_RSVD});
    send_frame(OP_TEXT, 1'b0, FORM_SHORT, 64'd0, 0);
    send_frame(OP_PING, 1'b1, FORM_SHORT, 64'd0, 0);
    send_frame(OP_PONG, 1'b0, FORM_EXT16, 64'd0, 0);
    send_frame(OP_CLOSE, 1'b0, FORM_EXT64, 64'd1, 1);
    wait_drained();

    start = bytes_sent;
    while (bytes_sent - start < RANDOM_BYTES) begin
      if (!paused && bytes_sent - start > RANDOM_BYTES / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      if (!long_done && bytes_sent - start > RANDOM_BYTES / 3) begin
        send_frame(OP_BINARY, 1'b1, FORM_EXT16, 64'd300, 300);
        long_done = 1'b1;
      end
      if ($urandom_range(0, 9) == 0) begin
        noise = 8'($urandom);
        if (noise[7] && frame_scoreboard::known_opcode(noise[3:0])) noise[7] = 1'b0;
        send_byte(noise);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          form = FORM_SHORT;
          len = ($urandom_range(0, 19) == 0) ? 64'd125 : 64'($urandom_range(0, 12));
        end else if (pick < 85) begin
          form = FORM_EXT16;
          len = 64'($urandom_range(0, 20));
        end else begin
          form = FORM_EXT64;
          len = 64'($urandom_range(0, 20));
        end
        send_frame(valid_ops[$urandom_range(0, 4)], 1'($urandom_range(0, 1)), form, len,
                   int'(len));
      end
    end

    // 64-bit length with the top bit set, left unfinished
    send_frame(OP_TEXT, 1'b1, FORM_EXT64, {1'b1, 55'd0, 8'h05}, 9);
    s_axis_tvalid <= 1'b0;

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
rtl/wsfp_pkg.sv
rtl/websocket_frame_parser.sv
tb/websocket_frame_parser_tb.sv
